// ===== src/cds_pkg.sv =====
// cds_pkg: shared sizes, opcodes, controller states and the command and
// status types that join the dominator controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package cds_pkg;

  // graph size
  localparam int NODES  = 64;
  localparam int NODE_W = $clog2(NODES);
  localparam int CNT_W  = NODE_W + 1;

  // input item opcodes
  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_RUN   = 2'd2;

  // controller states
  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD_RD,
    S_ADD_WR,
    S_REACH_RD,
    S_REACH_CHK,
    S_PASS,
    S_INIT,
    S_ITER,
    S_NODE,
    S_NODE_LOAD,
    S_SCAN,
    S_NODE_WR,
    S_NODE_NEXT,
    S_EMIT_START,
    S_EMIT_RD,
    S_EMIT_LD
  } ctrl_state_t;

  // one datapath command per cycle
  typedef enum logic [4:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_CLEAR,
    CMD_ADD_RD,
    CMD_ADD_WR,
    CMD_RUN_START,
    CMD_PASS_START,
    CMD_REACH_RD,
    CMD_REACH_CHK,
    CMD_INIT_WR,
    CMD_ITER_START,
    CMD_NODE_RD,
    CMD_NODE_LOAD,
    CMD_SCAN,
    CMD_NODE_WR,
    CMD_NODE_NEXT,
    CMD_EMIT_START,
    CMD_EMIT_RD,
    CMD_EMIT_LD
  } dp_cmd_t;

  // datapath status seen by the controller
  typedef struct packed {
    logic i_last;
    logic n_one;
    logic pass_grew;
    logic changed;
    logic node_reached;
    logic scan_done;
    logic out_free;
  } dp_status_t;

endpackage

// ===== src/cds_ram.sv =====
// cds_ram: generic single write port, single read port ram with
// registered read data. No dependencies.
`timescale 1ns / 1ps

module cds_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/cds_datapath.sv =====
// cds_datapath: node count register, predecessor and dominator memories,
// reach mask, scan counters and the result register.
// Depends on cds_pkg and cds_ram.
`timescale 1ns / 1ps

module cds_datapath
  import cds_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  dp_cmd_t           cmd,
  output dp_status_t        status,
  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data,
  input  logic [NODE_W-1:0] from_node,
  input  logic [NODE_W-1:0] to_node,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [NODE_W-1:0] node,
  output logic              reached,
  output logic [NODES-1:0]  dominators,
  output logic              last
);

  logic [CNT_W-1:0]  node_limit;
  logic [CNT_W-1:0]  n_eff;
  logic [CNT_W-1:0]  n_m1;
  logic [NODES-1:0]  live;
  logic [NODES-1:0]  self_bit;

  logic [NODE_W-1:0] from_q;
  logic [NODE_W-1:0] to_q;
  logic [NODE_W-1:0] idx;
  logic [CNT_W-1:0]  p;
  logic [NODE_W-1:0] p_d;
  logic              v_d;
  logic [NODES-1:0]  reach;
  logic              grew;
  logic              changed;
  logic [NODES-1:0]  row_valid;
  logic              pred_vld_d;
  logic [NODES-1:0]  pred_row;
  logic [NODES-1:0]  acc;
  logic [NODES-1:0]  old_row;
  logic [NODES-1:0]  new_row;

  logic              pred_we;
  logic [NODE_W-1:0] pred_raddr;
  logic [NODES-1:0]  pred_wdata;
  logic [NODES-1:0]  pred_rdata;
  logic [NODES-1:0]  pred_eff;
  logic              dom_we;
  logic [NODE_W-1:0] dom_raddr;
  logic [NODES-1:0]  dom_wdata;
  logic [NODES-1:0]  dom_rdata;
  logic              edge_ok;
  logic              hit;

  // effective node count, clamped into 1..NODES
  always_comb begin
    if (node_limit == '0) begin
      n_eff = CNT_W'(1);
    end else if (node_limit > CNT_W'(NODES)) begin
      n_eff = CNT_W'(NODES);
    end else begin
      n_eff = node_limit;
    end
  end

  assign n_m1     = n_eff - CNT_W'(1);
  assign live     = ~({NODES{1'b1}} << n_eff);
  assign self_bit = NODES'(1) << idx;
  assign edge_ok  = ({1'b0, from_q} < n_eff) && ({1'b0, to_q} < n_eff);

  // predecessor row as stored, empty rows read as zero
  assign pred_eff = pred_vld_d ? pred_rdata : '0;
  assign hit      = (|(pred_eff & reach & live)) && !reach[idx];
  assign new_row  = acc | self_bit;

  // predecessor memory: row t holds bit f for an edge f -> t
  assign pred_raddr = (cmd == CMD_ADD_RD) ? to_q : idx;
  assign pred_we    = (cmd == CMD_ADD_WR) && edge_ok;
  assign pred_wdata = pred_eff | (NODES'(1) << from_q);

  cds_ram #(.WIDTH(NODES), .DEPTH(NODES)) u_pred_ram (
    .clk   (clk),
    .we    (pred_we),
    .waddr (to_q),
    .wdata (pred_wdata),
    .raddr (pred_raddr),
    .rdata (pred_rdata)
  );

  // dominator memory write: initial rows or updated rows
  always_comb begin
    dom_we    = 1'b0;
    dom_wdata = new_row;
    case (cmd)
      CMD_INIT_WR: begin
        dom_we = 1'b1;
        if (idx == '0) begin
          dom_wdata = NODES'(1);
        end else if (reach[idx]) begin
          dom_wdata = live;
        end else begin
          dom_wdata = self_bit;
        end
      end
      CMD_NODE_WR: begin
        dom_we = (new_row != old_row);
      end
      default: begin
        dom_we = 1'b0;
      end
    endcase
  end

  assign dom_raddr = (cmd == CMD_SCAN) ? p[NODE_W-1:0] : idx;

  cds_ram #(.WIDTH(NODES), .DEPTH(NODES)) u_dom_ram (
    .clk   (clk),
    .we    (dom_we),
    .waddr (idx),
    .wdata (dom_wdata),
    .raddr (dom_raddr),
    .rdata (dom_rdata)
  );

  // config register
  always_ff @(posedge clk) begin
    if (rst) begin
      node_limit <= CNT_W'(NODES);
    end else if (cfg_wr_en) begin
      node_limit <= cfg_wr_data;
    end
  end

  // control state: row valid bits, reach mask, flags, counters
  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid <= '0;
      reach     <= '0;
      grew      <= 1'b0;
      changed   <= 1'b0;
      idx       <= '0;
      p         <= '0;
      v_d       <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      // result valid: set on load, dropped once taken
      if (cmd == CMD_EMIT_LD) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd)
        CMD_CLEAR: begin
          row_valid <= '0;
          reach     <= '0;
          changed   <= 1'b0;
        end
        CMD_ADD_WR: begin
          if (edge_ok) begin
            row_valid[to_q] <= 1'b1;
          end
        end
        CMD_RUN_START: begin
          reach <= NODES'(1);
          grew  <= 1'b0;
          idx   <= '0;
        end
        CMD_PASS_START: begin
          grew <= 1'b0;
          idx  <= '0;
        end
        CMD_REACH_CHK: begin
          if (hit) begin
            reach[idx] <= 1'b1;
            grew       <= 1'b1;
          end
          idx <= status.i_last ? '0 : idx + NODE_W'(1);
        end
        CMD_INIT_WR: begin
          idx <= idx + NODE_W'(1);
        end
        CMD_ITER_START: begin
          changed <= 1'b0;
          idx     <= NODE_W'(1);
        end
        CMD_NODE_LOAD: begin
          p   <= '0;
          v_d <= 1'b0;
        end
        CMD_SCAN: begin
          if (p < n_eff) begin
            v_d <= 1'b1;
            p   <= p + CNT_W'(1);
          end else begin
            v_d <= 1'b0;
          end
        end
        CMD_NODE_WR: begin
          if (new_row != old_row) begin
            changed <= 1'b1;
          end
        end
        CMD_NODE_NEXT: begin
          idx <= idx + NODE_W'(1);
        end
        CMD_EMIT_START: begin
          idx <= '0;
        end
        CMD_EMIT_LD: begin
          idx <= idx + NODE_W'(1);
        end
        default: begin
          v_d <= 1'b0;
        end
      endcase
    end
  end

  // payload registers: latched item, scan pipeline, accumulators, result
  always_ff @(posedge clk) begin
    pred_vld_d <= row_valid[pred_raddr];
    p_d        <= p[NODE_W-1:0];
    case (cmd)
      CMD_LOAD: begin
        from_q <= from_node;
        to_q   <= to_node;
      end
      CMD_NODE_LOAD: begin
        pred_row <= pred_eff & live & reach;
        acc      <= live;
      end
      CMD_SCAN: begin
        if (v_d) begin
          if (pred_row[p_d]) begin
            acc <= acc & dom_rdata;
          end
          if (p_d == idx) begin
            old_row <= dom_rdata;
          end
        end
      end
      CMD_EMIT_LD: begin
        node       <= idx;
        reached    <= reach[idx];
        dominators <= dom_rdata;
        last       <= status.i_last;
      end
      default: begin
      end
    endcase
  end

  // status to the controller
  always_comb begin
    status.i_last       = ({1'b0, idx} == n_m1);
    status.n_one        = (n_eff == CNT_W'(1));
    status.pass_grew    = grew || hit;
    status.changed      = changed;
    status.node_reached = reach[idx];
    status.scan_done    = v_d && ({1'b0, p_d} == n_m1);
    status.out_free     = !out_valid || out_ready;
  end

endmodule

// ===== src/cds_ctrl.sv =====
// cds_ctrl: controller state machine that sequences edge loads, the
// reachability passes, the dominator iterations and result output.
// Depends on cds_pkg.
`timescale 1ns / 1ps

module cds_ctrl
  import cds_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] opcode,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  ctrl_state_t state;
  ctrl_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = CMD_NONE;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (opcode)
            OP_ADD: begin
              cmd        = CMD_LOAD;
              state_next = S_ADD_RD;
            end
            OP_CLEAR: begin
              cmd = CMD_CLEAR;
            end
            OP_RUN: begin
              cmd        = CMD_RUN_START;
              state_next = S_REACH_RD;
            end
            default: begin
              cmd = CMD_NONE;
            end
          endcase
        end
      end
      S_ADD_RD: begin
        cmd        = CMD_ADD_RD;
        state_next = S_ADD_WR;
      end
      S_ADD_WR: begin
        cmd        = CMD_ADD_WR;
        state_next = S_IDLE;
      end
      // reachability: passes over all nodes until the mask stops growing
      S_REACH_RD: begin
        cmd        = CMD_REACH_RD;
        state_next = S_REACH_CHK;
      end
      S_REACH_CHK: begin
        cmd = CMD_REACH_CHK;
        if (!status.i_last) begin
          state_next = S_REACH_RD;
        end else if (status.pass_grew) begin
          state_next = S_PASS;
        end else begin
          state_next = S_INIT;
        end
      end
      S_PASS: begin
        cmd        = CMD_PASS_START;
        state_next = S_REACH_RD;
      end
      // initial dominator rows
      S_INIT: begin
        cmd = CMD_INIT_WR;
        if (status.i_last) begin
          state_next = S_ITER;
        end
      end
      // one sweep over nodes 1 and up
      S_ITER: begin
        cmd        = CMD_ITER_START;
        state_next = status.n_one ? S_EMIT_START : S_NODE;
      end
      S_NODE: begin
        if (status.node_reached) begin
          cmd        = CMD_NODE_RD;
          state_next = S_NODE_LOAD;
        end else begin
          state_next = S_NODE_NEXT;
        end
      end
      S_NODE_LOAD: begin
        cmd        = CMD_NODE_LOAD;
        state_next = S_SCAN;
      end
      S_SCAN: begin
        cmd = CMD_SCAN;
        if (status.scan_done) begin
          state_next = S_NODE_WR;
        end
      end
      S_NODE_WR: begin
        cmd        = CMD_NODE_WR;
        state_next = S_NODE_NEXT;
      end
      S_NODE_NEXT: begin
        cmd = CMD_NODE_NEXT;
        if (!status.i_last) begin
          state_next = S_NODE;
        end else if (status.changed) begin
          state_next = S_ITER;
        end else begin
          state_next = S_EMIT_START;
        end
      end
      // one result item per node
      S_EMIT_START: begin
        cmd        = CMD_EMIT_START;
        state_next = S_EMIT_RD;
      end
      S_EMIT_RD: begin
        if (status.out_free) begin
          cmd        = CMD_EMIT_RD;
          state_next = S_EMIT_LD;
        end
      end
      S_EMIT_LD: begin
        cmd        = CMD_EMIT_LD;
        state_next = status.i_last ? S_IDLE : S_EMIT_RD;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== src/cfg_dominator_sets.sv =====
// cfg_dominator_sets: one item at a time; add edge reads and writes the predecessor row
// while the input is held off, clear graph and opcode 3 leave the block idle. run: R
// reach passes over all nodes (R up to n), rows are seeded, then sweeps run until no row
// changes (one dominator row read per cycle), then the n result items are sent, held by
// out_ready; n is the node count.
// Reset (rst, synchronous) empties the graph, sets the node count to 64, idles.
`timescale 1ns / 1ps

module cfg_dominator_sets
  import cds_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        opcode,
  input  logic [NODE_W-1:0] from_node,
  input  logic [NODE_W-1:0] to_node,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [NODE_W-1:0] node,
  output logic              reached,
  output logic [NODES-1:0]  dominators,
  output logic              last
);

  dp_cmd_t    cmd;
  dp_status_t status;

  // sequencing
  cds_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .opcode   (opcode),
    .status   (status),
    .cmd      (cmd)
  );

  // storage and arithmetic
  cds_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .from_node   (from_node),
    .to_node     (to_node),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .node        (node),
    .reached     (reached),
    .dominators  (dominators),
    .last        (last)
  );

endmodule

// ===== test/cfg_dominator_sets_test.sv =====
// cfg_dominator_sets_test: self-checking bench for the dominator-set engine,
// with a scoreboard that predicts every node row from its own graph copy.
// Depends on cds_pkg and cfg_dominator_sets.
`timescale 1ns / 1ps

module cfg_dominator_sets_test;
  import cds_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int HOLD_CYCLES  = 400;
  localparam int RANDOM_ITEMS = 480;
  localparam int BIG_PHASE    = 12;

  // one expected node row of a run
  typedef struct {
    logic [NODE_W-1:0] node;
    logic              reached;
    logic [NODES-1:0]  dominators;
    logic              last;
  } dom_row_t;

  // graph copy, node count and the rows still owed by the block
  class dominator_board;
    logic [NODES-1:0] adj [NODES];
    logic [CNT_W-1:0] count_reg;
    dom_row_t         pending_rows [$];
    int               mismatches;

    function new();
      foreach (adj[i]) adj[i] = '0;
      count_reg  = CNT_W'(NODES);
      mismatches = 0;
    endfunction

    function int nodes();
      if (count_reg == 0) return 1;
      if (count_reg > NODES) return NODES;
      return int'(count_reg);
    endfunction

    function void set_count(logic [CNT_W-1:0] value);
      count_reg = value;
    endfunction

    // reachability, then dominator sets swept in node order to a fixed point
    function void predict_run(int n);
      logic [NODES-1:0] live, seen, grown, acc;
      logic [NODES-1:0] rows [NODES];
      logic             moved;
      dom_row_t         row;
      live  = (n >= NODES) ? '1 : ((64'd1 << n) - 64'd1);
      seen  = 64'd1;
      moved = 1'b1;
      while (moved) begin
        grown = seen;
        for (int u = 0; u < n; u++)
          if (seen[u]) grown |= adj[u] & live;
        moved = (grown != seen);
        seen  = grown;
      end
      for (int i = 0; i < n; i++) rows[i] = seen[i] ? live : (64'd1 << i);
      rows[0] = 64'd1;
      moved = 1'b1;
      while (moved) begin
        moved = 1'b0;
        for (int i = 1; i < n; i++) begin
          if (!seen[i]) continue;
          acc = live;
          for (int p = 0; p < n; p++)
            if (seen[p] && adj[p][i]) acc &= rows[p];
          acc[i] = 1'b1;
          if (acc != rows[i]) begin
            rows[i] = acc;
            moved   = 1'b1;
          end
        end
      end
      for (int i = 0; i < n; i++) begin
        row.node       = NODE_W'(i);
        row.reached    = seen[i];
        row.dominators = rows[i];
        row.last       = (i == n - 1);
        pending_rows.insert(pending_rows.size(), row);
      end
    endfunction

    function void note_item(logic [1:0] op, logic [NODE_W-1:0] src,
                            logic [NODE_W-1:0] dst);
      int n;
      n = nodes();
      case (op)
        OP_ADD: begin
          if (src < n && dst < n) adj[src][dst] = 1'b1;
        end
        OP_CLEAR: begin
          foreach (adj[i]) adj[i] = '0;
        end
        OP_RUN: begin
          predict_run(n);
        end
        default: begin
        end
      endcase
    endfunction

    function void check_row(logic [NODE_W-1:0] nd, logic rch, logic [NODES-1:0] dm,
                            logic lst);
      dom_row_t want;
      if (pending_rows.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result item for node %0d", nd);
        return;
      end
      want = pending_rows[0];
      pending_rows.delete(0);
      if (want.node !== nd || want.reached !== rch || want.dominators !== dm ||
          want.last !== lst) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("mismatch: exp node %0d reached %0b dom %h last %0b",
                   want.node, want.reached, want.dominators, want.last);
          $display("          got node %0d reached %0b dom %h last %0b",
                   nd, rch, dm, lst);
        end
      end
    endfunction
  endclass

  logic              clk;
  logic              rst;
  logic              cfg_wr_en;
  logic [CNT_W-1:0]  cfg_wr_data;
  logic              in_valid;
  logic              in_ready;
  logic [1:0]        opcode;
  logic [NODE_W-1:0] from_node;
  logic [NODE_W-1:0] to_node;
  logic              out_valid;
  logic              out_ready;
  logic [NODE_W-1:0] node;
  logic              reached;
  logic [NODES-1:0]  dominators;
  logic              last;

  dominator_board board = new();
  int items_sent = 0;
  int hold_asked = 0;
  bit tx_steady  = 1'b0;
  bit rx_steady  = 1'b0;

  cfg_dominator_sets i_dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .opcode      (opcode),
    .from_node   (from_node),
    .to_node     (to_node),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .node        (node),
    .reached     (reached),
    .dominators  (dominators),
    .last        (last)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // run limit
  initial begin
    #200000000;
    $display("cfg_dominator_sets regression: fail");
    $finish;
  end

  // result receiver with random stalls and requested long hold-offs
  initial begin : receiver
    int hold_left = 0;
    int hold_taken = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_asked != hold_taken) begin
        hold_taken = hold_asked;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = rx_steady || ($urandom_range(99) >= 24);
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      board.check_row(node, reached, dominators, last);
  end

  // offer one item after random idle cycles, hold it until accepted
  task automatic push_item(input logic [1:0] op, input int src, input int dst);
    int n;
    n = board.nodes();
    while (!tx_steady && $urandom_range(99) < 24) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid  = 1'b1;
    opcode    = op;
    from_node = NODE_W'(src);
    to_node   = NODE_W'(dst);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_item(op, from_node, to_node);
    if (op == OP_CLEAR || op == OP_RUN || (op == OP_ADD && src < n && dst < n))
      items_sent++;
  endtask

  // sender pause until every owed row has arrived
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (board.pending_rows.size() != 0) @(negedge clk);
  endtask

  // node count write once the block has gone idle
  task automatic write_count(input int value);
    wait_drained();
    repeat (8) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value[CNT_W-1:0];
    @(negedge clk);
    cfg_wr_en = 1'b0;
    board.set_count(value[CNT_W-1:0]);
  endtask

  // edge with an occasional ignored or stray item ahead of it
  task automatic push_edge(input int src, input int dst);
    if ($urandom_range(9) == 0) begin
      if ($urandom_range(1) == 0)
        push_item(OP_UNUSED, $urandom_range(0, 63), $urandom_range(0, 63));
      else
        push_item(OP_ADD, $urandom_range(0, 63), $urandom_range(0, 63));
    end
    push_item(OP_ADD, src, dst);
  endtask

  // one graph: count, optional clear, shaped edges, run, maybe more edges and a rerun
  task automatic random_phase(input int phase_no, input bit squeeze);
    int cnt;
    int n;
    int shape;
    cnt = 0;
    if (phase_no == BIG_PHASE) begin
      cnt = $urandom_range(64, 127);
    end else begin
      case ($urandom_range(11))
        0:       cnt = $urandom_range(0, 1);
        1, 2:    cnt = $urandom_range(13, 24);
        default: cnt = $urandom_range(2, 12);
      endcase
    end
    write_count(cnt);
    n = board.nodes();
    if (squeeze) hold_asked++;
    if ($urandom_range(3) != 0) push_item(OP_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63));
    shape = $urandom_range(3);
    // a reversed chain at full size would need a sweep per node
    if (n > 24 && shape == 2) shape = 1;
    case (shape)
      0: begin
        repeat ($urandom_range(n, 2 * n))
          push_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1));
      end
      1: begin
        for (int i = 0; i < n - 1; i++) push_edge(i, i + 1);
        repeat (n / 2) push_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1));
      end
      2: begin
        if (n > 1) push_edge(0, n - 1);
        for (int i = n - 1; i >= 2; i--) push_edge(i, i - 1);
        repeat (2) push_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1));
      end
      default: begin
        for (int i = 1; i < n; i++) push_edge($urandom_range(0, i - 1), i);
        for (int i = 1; i < n; i++)
          if ($urandom_range(3) == 0) push_edge(i, $urandom_range(0, i));
      end
    endcase
    push_item(OP_RUN, $urandom_range(0, 63), $urandom_range(0, 63));
    if (squeeze || $urandom_range(2) == 0) begin
      if (!squeeze && $urandom_range(1) == 0) wait_drained();
      repeat ($urandom_range(1, 4))
        push_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1));
      push_item(OP_RUN, $urandom_range(0, 63), $urandom_range(0, 63));
    end
  endtask

  // main sequence
  initial begin
    int phase_no;
    rst         = 1'b1;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = '0;
    in_valid    = 1'b0;
    opcode      = OP_ADD;
    from_node   = '0;
    to_node     = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    // empty graph at the reset count
    push_item(OP_RUN, 0, 0);

    // zero count acts as a single node
    write_count(0);
    push_item(OP_RUN, 63, 63);

    // oversize count, extreme nodes, self loop, edge into entry, duplicate, unused opcode
    write_count(127);
    push_item(OP_ADD, 0, 63);
    push_item(OP_ADD, 63, 0);
    push_item(OP_ADD, 0, 0);
    push_item(OP_ADD, 0, 63);
    push_item(OP_UNUSED, 63, 63);
    push_item(OP_RUN, 0, 0);

    // diamond, self loop, edges past the count, then clear
    write_count(5);
    push_item(OP_CLEAR, 0, 0);
    push_item(OP_ADD, 0, 1);
    push_item(OP_ADD, 0, 2);
    push_item(OP_ADD, 1, 3);
    push_item(OP_ADD, 2, 3);
    push_item(OP_ADD, 3, 3);
    push_item(OP_ADD, 5, 1);
    push_item(OP_ADD, 1, 5);
    push_item(OP_RUN, 0, 0);
    push_item(OP_CLEAR, 0, 0);
    push_item(OP_RUN, 0, 0);

    // count lowered below stored edges, then raised again
    write_count(8);
    push_item(OP_ADD, 0, 7);
    push_item(OP_ADD, 7, 1);
    write_count(4);
    push_item(OP_RUN, 0, 0);
    write_count(8);
    push_item(OP_RUN, 0, 0);

    // random graphs
    items_sent = 0;
    phase_no   = 0;
    while (items_sent < RANDOM_ITEMS) begin
      tx_steady = (phase_no >= 6 && phase_no <= 9);
      rx_steady = tx_steady;
      random_phase(phase_no, phase_no == 3 || phase_no == 17);
      phase_no++;
    end

    wait_drained();
    repeat (40) @(negedge clk);
    if (board.mismatches == 0 && board.pending_rows.size() == 0) begin
      $display("cfg_dominator_sets regression: pass");
    end else begin
      $display("cfg_dominator_sets regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/cds_pkg.sv
src/cds_ram.sv
src/cds_datapath.sv
src/cds_ctrl.sv
src/cfg_dominator_sets.sv
test/cfg_dominator_sets_test.sv
